// ----- design/ddmsf_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ddmsf_pkg - constants for the wheel speed framer
// Fixed-point wheel constants, frame layout and the CRC-16/Modbus byte step.
// ---------------------------------------------------------------------------
package ddmsf_pkg;

	// Q20 constants: half track 0.1925 m and 60/436.46 rpm per mm/s
	localparam logic signed [18:0] HALF_TRACK_Q20 = 19'sd201851;
	localparam logic        [17:0] RPM_SCALE_Q20  = 18'd144147;

	// Frame layout
	localparam int HEAD_LEN = 7;
	localparam logic [7:0] FRAME_HEAD [HEAD_LEN] =
		'{8'h01, 8'h10, 8'h20, 8'h88, 8'h00, 8'h02, 8'h04};

	localparam logic [3:0] IDX_LEFT_HI  = 4'd7;
	localparam logic [3:0] IDX_LEFT_LO  = 4'd8;
	localparam logic [3:0] IDX_RIGHT_HI = 4'd9;
	localparam logic [3:0] IDX_RIGHT_LO = 4'd10;
	localparam logic [3:0] IDX_CRC_LO   = 4'd11;
	localparam logic [3:0] IDX_LAST     = 4'd12;

	// CRC-16/Modbus
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// One byte through the reflected CRC
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
		input logic [7:0] data);
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// CRC over the fixed header, folded at elaboration
	function automatic logic [15:0] crc_head();
		logic [15:0] c;
		c = CRC_INIT;
		for (int k = 0; k < HEAD_LEN; k++) begin
			c = crc_byte(c, FRAME_HEAD[k]);
		end
		return c;
	endfunction

	localparam logic [15:0] CRC_HEAD = crc_head();

endpackage

// ----- design/diff_drive_modbus_speed_framer.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// diff_drive_modbus_speed_framer - wheel speed command framer
// Turns linear speed and yaw rate into a 13-byte Modbus write frame.
// ---------------------------------------------------------------------------
// Each accepted command word (linear_speed in mm/s, yaw_rate in mrad/s) is
// converted to right and left wheel rpm in Q20 fixed point and sent as one
// 13-byte frame: 01 10 20 88 00 02 04, left rpm (hi, lo), right rpm (hi, lo),
// then the CRC-16/Modbus low byte and high byte; last_byte marks the CRC high
// byte. A command passes through the pipeline stages and the output register
// before its first byte can leave. The output register sends one byte per
// cycle while byte_stall is low, and it sets the sustained command rate.
// The pipeline keeps taking commands while a frame is being sent and only
// stalls the input once all nine stages are full.
module diff_drive_modbus_speed_framer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  logic signed [15:0] linear_speed,
	input  logic signed [15:0] yaw_rate,
	output logic              byte_valid,
	input  logic              byte_stall,
	output logic        [7:0] frame_byte,
	output logic              last_byte
);
	import ddmsf_pkg::*;

	// Stage valids
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	// Stage advance (slot empty or moving on)
	logic adv1, adv2, adv3, adv4, adv5, adv6, adv7, adv8, adv9;
	logic ser_ready, byte_take, load_w;

	// Stage payloads
	logic signed [15:0] v_s1;
	logic signed [34:0] turn_s1;
	logic signed [36:0] sum_r_s2, sum_l_s2;
	logic        [35:0] mag_r_s3, mag_l_s3;
	logic               neg_r_s3, neg_l_s3;
	logic        [35:0] pp_rh_s4, pp_rl_s4, pp_lh_s4, pp_ll_s4;
	logic               neg_r_s4, neg_l_s4;
	logic        [15:0] right_s5, left_s5;
	logic        [15:0] right_s6, left_s6, crc_s6;
	logic        [15:0] right_s7, left_s7, crc_s7;
	logic        [15:0] right_s8, left_s8, crc_s8;
	logic        [15:0] right_s9, left_s9, crc_s9;

	// Serializer
	logic        buf_valid_q;
	logic  [3:0] idx_q;
	logic [15:0] left_q, right_q, crc_q;

	// Combinational helpers
	logic signed [34:0] turn_w;
	logic signed [36:0] vq_w;
	logic        [53:0] prod_r_w, prod_l_w;
	logic        [13:0] q_r_w, q_l_w;

	// Flow control: backpressure ripples from the serializer
	assign byte_take = buf_valid_q && !byte_stall;
	assign ser_ready = !buf_valid_q || (byte_take && (idx_q == IDX_LAST));
	assign adv9 = !vld_s9 || ser_ready;
	assign adv8 = !vld_s8 || adv9;
	assign adv7 = !vld_s7 || adv8;
	assign adv6 = !vld_s6 || adv7;
	assign adv5 = !vld_s5 || adv6;
	assign adv4 = !vld_s4 || adv5;
	assign adv3 = !vld_s3 || adv4;
	assign adv2 = !vld_s2 || adv3;
	assign adv1 = !vld_s1 || adv2;
	assign cmd_stall = !adv1;
	assign load_w = ser_ready && vld_s9;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else begin
			if (adv1) vld_s1 <= cmd_valid;
			if (adv2) vld_s2 <= vld_s1;
			if (adv3) vld_s3 <= vld_s2;
			if (adv4) vld_s4 <= vld_s3;
			if (adv5) vld_s5 <= vld_s4;
			if (adv6) vld_s6 <= vld_s5;
			if (adv7) vld_s7 <= vld_s6;
			if (adv8) vld_s8 <= vld_s7;
			if (adv9) vld_s9 <= vld_s8;
		end
	end

	// Stage 1: yaw times half track
	assign turn_w = $signed(yaw_rate) * HALF_TRACK_Q20;

	always_ff @(posedge clk) begin
		if (adv1 && cmd_valid) begin
			v_s1    <= linear_speed;
			turn_s1 <= turn_w;
		end
	end

	// Stage 2: v*2^20 plus and minus turn
	assign vq_w = {v_s1[15], v_s1, 20'd0};

	always_ff @(posedge clk) begin
		if (adv2 && vld_s1) begin
			sum_r_s2 <= vq_w + 37'(turn_s1);
			sum_l_s2 <= vq_w - 37'(turn_s1);
		end
	end

	// Stage 3: sign and magnitude
	always_ff @(posedge clk) begin
		if (adv3 && vld_s2) begin
			neg_r_s3 <= sum_r_s2[36];
			neg_l_s3 <= sum_l_s2[36];
			mag_r_s3 <= sum_r_s2[36] ? 36'(-sum_r_s2) : sum_r_s2[35:0];
			mag_l_s3 <= sum_l_s2[36] ? 36'(-sum_l_s2) : sum_l_s2[35:0];
		end
	end

	// Stage 4: 18x18 partial products of magnitude times rpm scale
	always_ff @(posedge clk) begin
		if (adv4 && vld_s3) begin
			neg_r_s4 <= neg_r_s3;
			neg_l_s4 <= neg_l_s3;
			pp_rh_s4 <= mag_r_s3[35:18] * RPM_SCALE_Q20;
			pp_rl_s4 <= mag_r_s3[17:0] * RPM_SCALE_Q20;
			pp_lh_s4 <= mag_l_s3[35:18] * RPM_SCALE_Q20;
			pp_ll_s4 <= mag_l_s3[17:0] * RPM_SCALE_Q20;
		end
	end

	// Stage 5: combine, drop 40 fraction bits, restore sign (left is negated)
	assign prod_r_w = {pp_rh_s4, 18'd0} + 54'(pp_rl_s4);
	assign prod_l_w = {pp_lh_s4, 18'd0} + 54'(pp_ll_s4);
	assign q_r_w = prod_r_w[53:40];
	assign q_l_w = prod_l_w[53:40];

	always_ff @(posedge clk) begin
		if (adv5 && vld_s4) begin
			right_s5 <= neg_r_s4 ? 16'(-{2'b00, q_r_w}) : {2'b00, q_r_w};
			left_s5  <= neg_l_s4 ? {2'b00, q_l_w} : 16'(-{2'b00, q_l_w});
		end
	end

	// Stages 6-9: CRC over the four speed bytes, one byte per stage
	always_ff @(posedge clk) begin
		if (adv6 && vld_s5) begin
			left_s6  <= left_s5;
			right_s6 <= right_s5;
			crc_s6   <= crc_byte(CRC_HEAD, left_s5[15:8]);
		end
		if (adv7 && vld_s6) begin
			left_s7  <= left_s6;
			right_s7 <= right_s6;
			crc_s7   <= crc_byte(crc_s6, left_s6[7:0]);
		end
		if (adv8 && vld_s7) begin
			left_s8  <= left_s7;
			right_s8 <= right_s7;
			crc_s8   <= crc_byte(crc_s7, right_s7[15:8]);
		end
		if (adv9 && vld_s8) begin
			left_s9  <= left_s8;
			right_s9 <= right_s8;
			crc_s9   <= crc_byte(crc_s8, right_s8[7:0]);
		end
	end

	// Serializer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_valid_q <= 1'b0;
			idx_q       <= 4'd0;
		end else begin
			if (byte_take) begin
				if (idx_q == IDX_LAST) buf_valid_q <= 1'b0;
				else idx_q <= idx_q + 4'd1;
			end
			if (load_w) begin
				buf_valid_q <= 1'b1;
				idx_q       <= 4'd0;
			end
		end
	end

	// Serializer frame data
	always_ff @(posedge clk) begin
		if (load_w) begin
			left_q  <= left_s9;
			right_q <= right_s9;
			crc_q   <= crc_s9;
		end
	end

	// Byte select
	always_comb begin
		case (idx_q)
			IDX_LEFT_HI:  frame_byte = left_q[15:8];
			IDX_LEFT_LO:  frame_byte = left_q[7:0];
			IDX_RIGHT_HI: frame_byte = right_q[15:8];
			IDX_RIGHT_LO: frame_byte = right_q[7:0];
			IDX_CRC_LO:   frame_byte = crc_q[7:0];
			IDX_LAST:     frame_byte = crc_q[15:8];
			default:      frame_byte = FRAME_HEAD[idx_q[2:0]];
		endcase
	end

	assign byte_valid = buf_valid_q;
	assign last_byte  = (idx_q == IDX_LAST);

`ifndef ASSERT_OFF
	// An accepted command always lands in stage 1
	a_cmd_lands: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> vld_s1)
		else $error("accepted command lost at stage 1");

	// Mid-frame bytes step the index by one and keep the frame open
	a_idx_step: assert property (@(posedge clk) disable iff (!arst_n)
		byte_take && !last_byte |=> byte_valid && (idx_q == $past(idx_q) + 4'd1))
		else $error("frame index did not advance");

	// A blocked last stage holds its word
	a_s9_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s9 && !ser_ready |=> vld_s9 && $stable(crc_s9) && $stable(left_s9))
		else $error("stage 9 word changed while blocked");

	// A frame opens with the slave address byte
	a_head: assert property (@(posedge clk) disable iff (!arst_n)
		$past(load_w) |-> byte_valid && (idx_q == 4'd0) && (frame_byte == FRAME_HEAD[0]))
		else $error("frame did not start at the header");
`endif

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top - testbench for the wheel speed command framer
// Drives speed/yaw command words and checks every byte of each 13-byte
// Modbus frame. Expected frames come from an independent fixed-point model.
// ---------------------------------------------------------------------------
// A directed table runs first: zero, the field extremes, truncation toward
// zero near the origin, pure rotation and straight runs. A few rows carry
// wheel rpm typed in by hand. Then come about 230 random commands. Both
// sides idle at random. Once, the byte side holds off long enough for the
// pipeline to fill and stall the command side.
module tb_top;

	// Wheel math constants, Q20
	localparam longint HALF_TRACK = 64'sd201851;
	localparam longint RPM_SCALE  = 64'sd144147;
	localparam longint ONE_Q20    = 64'sd1048576;

	// Frame layout and CRC-16/Modbus
	localparam int FRAME_LEN = 13;
	localparam int CRC_SPAN  = 11;
	localparam int HDR_LEN   = 7;
	localparam int POS_LEFT_HI  = 7;
	localparam int POS_LEFT_LO  = 8;
	localparam int POS_RIGHT_HI = 9;
	localparam int POS_RIGHT_LO = 10;
	localparam int POS_CRC_LO   = 11;
	localparam int POS_CRC_HI   = 12;
	localparam logic [7:0] HDR [HDR_LEN] =
		'{8'h01, 8'h10, 8'h20, 8'h88, 8'h00, 8'h02, 8'h04};
	localparam logic [15:0] CRC_SEED      = 16'hFFFF;
	localparam logic [15:0] CRC_POLY_REFL = 16'hA001;

	// Run shape
	localparam int N_RANDOM    = 230;
	localparam int IDLE_PCT    = 21;
	localparam int HOLD_AT     = 1000;
	localparam int HOLD_LEN    = 300;
	localparam int RX_QUIET_LO = 2200;
	localparam int RX_QUIET_HI = 3000;
	localparam int TX_QUIET_LO = 120;
	localparam int TX_QUIET_HI = 170;
	localparam int DRAIN_CYCLES = 40;

	// Directed row: command word plus optional hand-typed wheel rpm
	typedef struct packed {
		logic signed [15:0] v;
		logic signed [15:0] yaw;
		logic               typed;
		logic signed [15:0] left;
		logic signed [15:0] right;
	} cmd_row_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} frame_slot_t;

	localparam int N_DIR = 21;
	localparam cmd_row_t DIR_ROWS [N_DIR] = '{
		'{16'sd0,      16'sd0,      1'b1, 16'sd0,     16'sd0},     // at rest
		'{16'sd1,      16'sd0,      1'b1, 16'sd0,     16'sd0},     // below one rpm
		'{16'sd32767,  16'sd0,      1'b1, -16'sd4504, 16'sd4504},  // full ahead
		'{-16'sd32768, 16'sd0,      1'b1, 16'sd4504,  -16'sd4504}, // full astern
		'{16'sd0,      16'sd32767,  1'b0, 16'sd0,     16'sd0},     // spin, max yaw
		'{16'sd0,      -16'sd32768, 1'b0, 16'sd0,     16'sd0},
		'{16'sd32767,  16'sd32767,  1'b0, 16'sd0,     16'sd0},
		'{-16'sd32768, -16'sd32768, 1'b0, 16'sd0,     16'sd0},
		'{16'sd32767,  -16'sd32768, 1'b0, 16'sd0,     16'sd0},
		'{-16'sd32768, 16'sd32767,  1'b0, 16'sd0,     16'sd0},
		'{-16'sd1,     16'sd0,      1'b0, 16'sd0,     16'sd0},     // trunc toward zero
		'{-16'sd1,     -16'sd1,     1'b0, 16'sd0,     16'sd0},
		'{16'sd8,      16'sd0,      1'b0, 16'sd0,     16'sd0},
		'{-16'sd8,     16'sd0,      1'b0, 16'sd0,     16'sd0},
		'{16'sd7,      16'sd1,      1'b0, 16'sd0,     16'sd0},
		'{16'sh5555,   16'sh2AAA,   1'b0, 16'sd0,     16'sd0},     // bit patterns
		'{16'shAAAA,   16'sh5555,   1'b0, 16'sd0,     16'sd0},
		'{16'sd100,    16'sd0,      1'b0, 16'sd0,     16'sd0},     // straight
		'{16'sd0,      16'sd1000,   1'b0, 16'sd0,     16'sd0},     // pure rotation
		'{16'sd1000,   -16'sd1000,  1'b0, 16'sd0,     16'sd0},
		'{-16'sd437,   16'sd520,    1'b0, 16'sd0,     16'sd0}
	};

	logic              clk;
	logic              arst_n;
	logic              cmd_valid;
	logic              cmd_stall;
	logic signed [15:0] linear_speed;
	logic signed [15:0] yaw_rate;
	logic              byte_valid;
	logic              byte_stall;
	logic        [7:0] frame_byte;
	logic              last_byte;

	frame_slot_t frame_bytes_due [$];
	int err_cnt;
	int cmds_sent;
	int bytes_checked;
	int frames_checked;
	int cmd_stall_cycles;
	int rx_cycle;
	int hold_left;
	bit tx_gaps;

	diff_drive_modbus_speed_framer u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_stall    (cmd_stall),
		.linear_speed (linear_speed),
		.yaw_rate     (yaw_rate),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.frame_byte   (frame_byte),
		.last_byte    (last_byte)
	);

	// Clock and reset
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Run limit
	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// rpm = trunc(sum_q20 * scale / 2^40), toward zero
	function automatic longint wheel_rpm(input longint sum_q20);
		longint prod;
		longint mag;
		prod = sum_q20 * RPM_SCALE;
		mag = (prod < 0) ? -prod : prod;
		mag = mag >> 40;
		return (prod < 0) ? -mag : mag;
	endfunction

	function automatic logic signed [15:0] clamp16(input longint x);
		if (x > 32767)
			return 16'sd32767;
		if (x < -32768)
			return -16'sd32768;
		return x[15:0];
	endfunction

	// Build the whole frame for one command and queue its bytes
	task automatic queue_frame(input logic signed [15:0] v, input logic signed [15:0] yaw,
		input cmd_row_t row);
		longint vq;
		longint turn;
		logic signed [15:0] left;
		logic signed [15:0] right;
		logic [7:0] f [FRAME_LEN];
		logic [15:0] crc;
		frame_slot_t slot;
		vq = longint'(v) * ONE_Q20;
		turn = longint'(yaw) * HALF_TRACK;
		if (row.typed) begin
			left = row.left;
			right = row.right;
		end else begin
			right = clamp16(wheel_rpm(vq + turn));
			left = clamp16(-wheel_rpm(vq - turn));
		end
		for (int k = 0; k < HDR_LEN; k++)
			f[k] = HDR[k];
		f[POS_LEFT_HI] = left[15:8];
		f[POS_LEFT_LO] = left[7:0];
		f[POS_RIGHT_HI] = right[15:8];
		f[POS_RIGHT_LO] = right[7:0];
		crc = CRC_SEED;
		for (int k = 0; k < CRC_SPAN; k++) begin
			crc = crc ^ {8'h00, f[k]};
			for (int b = 0; b < 8; b++)
				crc = crc[0] ? ((crc >> 1) ^ CRC_POLY_REFL) : (crc >> 1);
		end
		f[POS_CRC_LO] = crc[7:0];
		f[POS_CRC_HI] = crc[15:8];
		for (int k = 0; k < FRAME_LEN; k++) begin
			slot.data = f[k];
			slot.last = (k == POS_CRC_HI);
			frame_bytes_due.push_back(slot);
		end
	endtask

	// Offer one command word, with random idle cycles ahead of it while gaps are on
	task automatic send_cmd(input logic signed [15:0] v, input logic signed [15:0] yaw,
		input cmd_row_t row);
		while (tx_gaps && $urandom_range(99) < IDLE_PCT) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		linear_speed <= v;
		yaw_rate <= yaw;
		do
			@(posedge clk);
		while (cmd_stall);
		queue_frame(v, yaw, row);
		cmds_sent++;
	endtask

	// Command side
	initial begin
		cmd_row_t no_row;
		logic signed [15:0] v;
		logic signed [15:0] yaw;
		int pick;
		no_row = '0;
		cmd_valid = 1'b0;
		linear_speed = '0;
		yaw_rate = '0;
		tx_gaps = 1'b1;
		@(posedge arst_n);
		@(posedge clk);

		for (int i = 0; i < N_DIR; i++)
			send_cmd(DIR_ROWS[i].v, DIR_ROWS[i].yaw, DIR_ROWS[i]);

		for (int i = 0; i < N_RANDOM; i++) begin
			tx_gaps = (i < TX_QUIET_LO) || (i > TX_QUIET_HI);
			pick = $urandom_range(99);
			v = 16'($urandom);
			yaw = 16'($urandom);
			if (pick < 25) begin
				// near the origin, where truncation matters
				v = 16'($urandom_range(400)) - 16'sd200;
				yaw = 16'($urandom_range(400)) - 16'sd200;
			end else if (pick < 33) begin
				yaw = '0;
			end else if (pick < 41) begin
				v = '0;
			end else if (pick < 50) begin
				v = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
				yaw = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
			end
			send_cmd(v, yaw, no_row);
		end
		cmd_valid <= 1'b0;

		while (frame_bytes_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d speed commands (%0d directed), checked %0d bytes in %0d frames",
			cmds_sent, N_DIR, bytes_checked, frames_checked);
		$display("Byte side held off %0d cycles once; command side saw %0d stalled cycles",
			HOLD_LEN, cmd_stall_cycles);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Byte side: random stalls, one long hold-off, one quiet stretch
	initial begin
		byte_stall = 1'b0;
		rx_cycle = 0;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			rx_cycle++;
			if (rx_cycle == HOLD_AT)
				hold_left = HOLD_LEN;
			if (hold_left > 0) begin
				byte_stall <= 1'b1;
				hold_left--;
			end else if (rx_cycle >= RX_QUIET_LO && rx_cycle <= RX_QUIET_HI) begin
				byte_stall <= 1'b0;
			end else begin
				byte_stall <= ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	// Check each accepted frame byte against the oldest one due
	always @(posedge clk) begin
		frame_slot_t due;
		if (arst_n) begin
			if (cmd_valid && cmd_stall)
				cmd_stall_cycles++;
			if (byte_valid && !byte_stall) begin
				if (frame_bytes_due.size() == 0) begin
					$error("frame_byte: got %02h with no byte due", frame_byte);
					err_cnt++;
				end else begin
					due = frame_bytes_due.pop_front();
					if (frame_byte !== due.data) begin
						$error("frame_byte: expected %02h, actual %02h", due.data, frame_byte);
						err_cnt++;
					end
					if (last_byte !== due.last) begin
						$error("last_byte: expected %0b, actual %0b", due.last, last_byte);
						err_cnt++;
					end
					bytes_checked++;
					if (due.last)
						frames_checked++;
				end
			end
		end
	end

endmodule

// ----- diff_drive_modbus_speed_framer.f -----
design/ddmsf_pkg.sv
design/diff_drive_modbus_speed_framer.sv
test/tb_top.sv
